/* sv/lkvt_pkg.sv */
// Shared types and constants of the linear key-value table.
// Depends on nothing; every other file of the block but lkvt_ram imports it.
package lkvt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ENTRY_W     = KEY_W + VAL_W;
  localparam int TOTAL_W     = 6;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_LOOKUP  = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_READOUT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_RM_RD,
    S_RM_WR,
    S_PASS_START,
    S_PASS_A,
    S_PASS_CMP,
    S_PASS_END,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  // operands and flags of the shared key comparator
  typedef struct packed {
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_rsp_t;

  // one port set of the entry store
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  // one result beat
  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } res_t;

endpackage

/* sv/lkvt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lkvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lkvt_cmp.sv */
// Shared signed key comparator: equality for searches, greater-than for sorting.
// Depends on lkvt_pkg.
module lkvt_cmp (
  input  lkvt_pkg::cmp_req_t req,
  output lkvt_pkg::cmp_rsp_t rsp
);
  import lkvt_pkg::*;

  always_comb begin
    rsp.eq = (req.a == req.b);
    rsp.gt = ($signed(req.a) > $signed(req.b));
  end

endmodule

/* sv/lkvt_seq.sv */
// Sequencer of the key-value table: search, insert, remove and bubble-sort readout.
// Depends on lkvt_pkg; drives the entry store and the shared comparator.
module lkvt_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  lkvt_pkg::action_t        action,
  input  logic [lkvt_pkg::KEY_W-1:0]   key,
  input  logic [lkvt_pkg::VAL_W-1:0]   value,
  output logic                     busy,
  output lkvt_pkg::mem_req_t       mem_req,
  input  logic [lkvt_pkg::ENTRY_W-1:0] mem_rdata,
  output lkvt_pkg::cmp_req_t       cmp_req,
  input  lkvt_pkg::cmp_rsp_t       cmp_rsp,
  output logic                     res_valid,
  output lkvt_pkg::res_t           res
);
  import lkvt_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     ptr, ptr_next;
  logic [CNT_W-1:0]     pass_end, pass_end_next;   // bubble pass bound j
  logic                 pend, pend_next;           // a search read is in flight
  logic [IDX_W-1:0]     pos, pos_next;
  logic [ENTRY_W-1:0]   carry, carry_next;         // larger entry carried along a pass
  action_t              cmd_action, cmd_action_next;
  logic [KEY_W-1:0]     cmd_key, cmd_key_next;
  logic [VAL_W-1:0]     cmd_value, cmd_value_next;
  logic [VAL_W-1:0]     hit_value, hit_value_next;
  res_t                 res_next;
  logic                 res_valid_next;

  logic [KEY_W-1:0]     rd_key;
  logic [VAL_W-1:0]     rd_value;
  logic                 hit, miss;

  assign rd_key   = mem_rdata[ENTRY_W-1 -: KEY_W];
  assign rd_value = mem_rdata[VAL_W-1:0];
  assign hit      = pend && cmp_rsp.eq;
  assign miss     = !hit && (ptr == count);
  assign busy     = (state != S_IDLE);

  // comparator operands: search key, or carried entry during a sort pass
  always_comb begin
    cmp_req.a = (state == S_PASS_CMP) ? carry[ENTRY_W-1 -: KEY_W] : cmd_key;
    cmp_req.b = rd_key;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_READOUT) begin
            if (count == '0) begin
              state_next = S_IDLE;
            end else if (count == CNT_W'(1)) begin
              state_next = S_EMIT_RD;
            end else begin
              state_next = S_PASS_START;
            end
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit && cmd_action == ACT_REMOVE) begin
          state_next = S_RM_RD;
        end else if (hit || miss) begin
          state_next = S_IDLE;
        end
      end
      S_RM_RD:      state_next = S_RM_WR;
      S_RM_WR:      state_next = S_IDLE;
      S_PASS_START: state_next = S_PASS_A;
      S_PASS_A:     state_next = S_PASS_CMP;
      S_PASS_CMP: begin
        if ((ptr + CNT_W'(2)) >= pass_end) begin
          state_next = S_PASS_END;
        end
      end
      S_PASS_END: begin
        state_next = (pass_end > CNT_W'(2)) ? S_PASS_START : S_EMIT_RD;
      end
      S_EMIT_RD:    state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (ptr == count) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  // datapath, store requests and result beats
  always_comb begin
    count_next      = count;
    ptr_next        = ptr;
    pass_end_next   = pass_end;
    pend_next       = 1'b0;
    pos_next        = pos;
    carry_next      = carry;
    cmd_action_next = cmd_action;
    cmd_key_next    = cmd_key;
    cmd_value_next  = cmd_value;
    hit_value_next  = hit_value;
    mem_req         = '0;
    res_valid_next  = 1'b0;
    res_next        = '0;
    res_next.status = ST_OK;
    res_next.last   = 1'b1;
    res_next.total  = TOTAL_W'(count);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_action_next = action;
          cmd_key_next    = key;
          cmd_value_next  = value;
          ptr_next        = '0;
          pass_end_next   = count;
          if (action == ACT_READOUT && count == '0) begin
            res_valid_next  = 1'b1;
            res_next.status = ST_NOT_FOUND;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          unique case (cmd_action)
            ACT_INSERT: begin
              res_valid_next  = 1'b1;
              res_next.status = ST_DUPLICATE;
            end
            ACT_LOOKUP: begin
              res_valid_next = 1'b1;
              res_next.value = rd_value;
            end
            default: begin
              pos_next       = IDX_W'(ptr - CNT_W'(1));
              hit_value_next = rd_value;
            end
          endcase
        end else if (miss) begin
          res_valid_next = 1'b1;
          if (cmd_action == ACT_INSERT) begin
            if (count == CNT_W'(TABLE_DEPTH)) begin
              res_next.status = ST_FULL;
            end else begin
              mem_req.we     = 1'b1;
              mem_req.waddr  = count[IDX_W-1:0];
              mem_req.wdata  = {cmd_key, cmd_value};
              count_next     = count + CNT_W'(1);
              res_next.total = TOTAL_W'(count + CNT_W'(1));
            end
          end else begin
            res_next.status = ST_NOT_FOUND;
          end
        end else begin
          mem_req.raddr = ptr[IDX_W-1:0];
          ptr_next      = ptr + CNT_W'(1);
          pend_next     = 1'b1;
        end
      end
      S_RM_RD: begin
        mem_req.raddr = IDX_W'(count - CNT_W'(1));
      end
      S_RM_WR: begin
        // last entry fills the freed slot
        mem_req.we     = 1'b1;
        mem_req.waddr  = pos;
        mem_req.wdata  = mem_rdata;
        count_next     = count - CNT_W'(1);
        res_valid_next = 1'b1;
        res_next.value = hit_value;
        res_next.total = TOTAL_W'(count - CNT_W'(1));
      end
      S_PASS_START: begin
        mem_req.raddr = '0;
        ptr_next      = '0;
      end
      S_PASS_A: begin
        carry_next    = mem_rdata;
        mem_req.raddr = IDX_W'(ptr + CNT_W'(1));
      end
      S_PASS_CMP: begin
        // smaller entry settles at ptr, larger one moves on
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr[IDX_W-1:0];
        if (cmp_rsp.gt) begin
          mem_req.wdata = mem_rdata;
        end else begin
          mem_req.wdata = carry;
          carry_next    = mem_rdata;
        end
        ptr_next      = ptr + CNT_W'(1);
        mem_req.raddr = IDX_W'(ptr + CNT_W'(2));
      end
      S_PASS_END: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = IDX_W'(pass_end - CNT_W'(1));
        mem_req.wdata = carry;
        pass_end_next = pass_end - CNT_W'(1);
      end
      S_EMIT_RD: begin
        mem_req.raddr = '0;
        ptr_next      = CNT_W'(1);
      end
      S_EMIT_OUT: begin
        res_valid_next = 1'b1;
        res_next.key   = rd_key;
        res_next.value = rd_value;
        res_next.last  = (ptr == count);
        if (ptr != count) begin
          mem_req.raddr = ptr[IDX_W-1:0];
          ptr_next      = ptr + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    pass_end   <= pass_end_next;
    pos        <= pos_next;
    carry      <= carry_next;
    cmd_action <= cmd_action_next;
    cmd_key    <= cmd_key_next;
    cmd_value  <= cmd_value_next;
    hit_value  <= hit_value_next;
    res        <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action != ACT_READOUT) |=> busy)
    else $error("accepted command did not start a search");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |-> (state == S_IDLE))
    else $error("final beat while sequencer still running");

  a_mid_emit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> (state == S_EMIT_OUT))
    else $error("non-final beat outside readout");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_SEARCH && state != S_RM_WR) |=> $stable(count))
    else $error("entry count changed outside insert or remove");

endmodule

/* sv/linear_key_value_table_top.sv */
// Top level of the linear key-value table: entry store, comparator and sequencer.
// Depends on lkvt_pkg, lkvt_ram, lkvt_cmp and lkvt_seq.
//
// A fixed table of TABLE_DEPTH (32) unique signed keys, each with a 32-bit value
// handle, kept unsorted in one 64-bit-wide RAM. A command is taken when start is
// high and busy is low; busy then stays high until it is finished (an empty readout
// never raises it), and the receiver cannot stall: every result beat sits on the
// result ports for exactly one cycle, marked by done, and last marks the final beat
// of a command. The next command may be issued in the cycle the final beat is shown.
// Every command runs a linear scan through the single RAM read port, one entry a
// cycle, with the shared comparator checking the entry read the cycle before.
// Steps, with n entries held (before the command):
//   insert, lookup: scan from slot 0 until a hit at slot p or all n slots are checked;
//   remove: as a lookup, then on a hit read the last entry (S_RM_RD) and write
//   it into the hole (S_RM_WR); a miss ends the command.
//   readout: a bubble sort in place, one pass per bound j = n down to 2, then
//   a fetch of slot 0 and one beat a cycle for all n entries; an empty table
//   gives one not-found beat right after the command.
// Insert refuses a key already held (status 2, even when full) and a full table
// (status 3). Remove and lookup of a missing key give status 1. The sort leaves
// the store in key order, so later scans see the sorted order. entry_total
// reports the count after the command, six bits wide. The RAM needs no clearing:
// data of slots at or above the entry count is never used.
module linear_key_value_table_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [1:0]                           action,
  input  logic signed [lkvt_pkg::KEY_W-1:0]    key,
  input  logic [lkvt_pkg::VAL_W-1:0]           value,
  output logic                                 busy,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic signed [lkvt_pkg::KEY_W-1:0]    out_key,
  output logic [lkvt_pkg::VAL_W-1:0]           out_value,
  output logic [lkvt_pkg::TOTAL_W-1:0]         entry_total,
  output logic                                 last
);
  import lkvt_pkg::*;

  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  cmp_req_t           cmp_req;
  cmp_rsp_t           cmp_rsp;
  res_t               res;

  // entry store: key in the upper word, value handle in the lower
  lkvt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // one comparator serves both the search and the sort passes
  lkvt_cmp u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  lkvt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action_t'(action)),
    .key       (key),
    .value     (value),
    .busy      (busy),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .cmp_req   (cmp_req),
    .cmp_rsp   (cmp_rsp),
    .res_valid (done),
    .res       (res)
  );

  // result beat straight from the sequencer's output register
  assign status      = res.status;
  assign out_key     = res.key;
  assign out_value   = res.value;
  assign entry_total = res.total;
  assign last        = res.last;

endmodule
